/* rtl/topk_pkg.sv */
package topk_pkg;

  // Fixed field widths of the record and of one listing beat.
  localparam int unsigned NAME_W  = 64;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned CNT_W   = RANK_W + 1;

  // Default number of table entries.
  localparam int unsigned DEPTH_DEF = 10;

  typedef logic [CNT_W-1:0] cnt_t;

  // One stored record.
  typedef struct packed {
    logic [NAME_W-1:0]         name;
    logic signed [SCORE_W-1:0] score;
    logic [STAMP_W-1:0]        stamp;
  } record_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              insert;
    logic              emit;
    logic [RANK_W-1:0] rank;
    logic              last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cnt_t count;
  } sts_t;

endpackage

/* rtl/topk_in_if.sv */
interface topk_in_if;
  import topk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [NAME_W-1:0]         name_tag;
  logic signed [SCORE_W-1:0] score;
  logic [STAMP_W-1:0]        stamp;

  modport source (output valid, output name_tag, output score, output stamp, input ready);
  modport sink   (input valid, input name_tag, input score, input stamp, output ready);
endinterface

/* rtl/topk_out_if.sv */
interface topk_out_if;
  import topk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [RANK_W-1:0]         rank;
  logic [NAME_W-1:0]         entry_name;
  logic signed [SCORE_W-1:0] entry_score;
  logic [STAMP_W-1:0]        entry_stamp;
  logic                      is_new;
  logic                      last;

  modport source (
    output valid, output rank, output entry_name, output entry_score,
    output entry_stamp, output is_new, output last, input ready
  );
  modport sink (
    input valid, input rank, input entry_name, input entry_score,
    input entry_stamp, input is_new, input last, output ready
  );
endinterface

/* rtl/topk_dp.sv */
module topk_dp #(
  parameter int unsigned TableDepth = topk_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  topk_pkg::cmd_t                cmd_i,
  output topk_pkg::sts_t                sts_o,
  input  topk_pkg::record_t             rec_i,
  output topk_pkg::record_t             out_rec_o,
  output logic [topk_pkg::RANK_W-1:0]   out_rank_o,
  output logic                          out_new_o,
  output logic                          out_last_o
);
  import topk_pkg::*;

  localparam int unsigned CntW = $clog2(TableDepth + 1);

  record_t               cell_q   [TableDepth];
  record_t               cell_d   [TableDepth];
  record_t               prev_rec [TableDepth];
  record_t               next_rec [TableDepth];
  logic [TableDepth-1:0] new_q, new_d;
  logic [TableDepth-1:0] next_new;
  logic [TableDepth-1:0] ge, prev_ge, prev_ok;
  logic [CntW-1:0]       cnt_q, cnt_d;

  record_t           out_rec_q;
  logic [RANK_W-1:0] out_rank_q;
  logic              out_new_q;
  logic              out_last_q;

  // Each cell compares its score against the new record. The table is
  // sorted, so the cells that hold a greater or equal score form a prefix.
  always_comb begin
    for (int k = 0; k < TableDepth; k++) begin
      ge[k] = (CntW'(k) < cnt_q) && ($signed(cell_q[k].score) >= $signed(rec_i.score));
    end
  end

  // Neighbor taps of each cell: the one above for insertion, the one below
  // for the listing rotation.
  for (genvar k = 0; k < TableDepth; k++) begin : g_tap
    if (k == 0) begin : g_head
      assign prev_rec[k] = rec_i;
      assign prev_ge[k]  = 1'b1;
      assign prev_ok[k]  = 1'b0;
    end else begin : g_body
      assign prev_rec[k] = cell_q[k-1];
      assign prev_ge[k]  = ge[k-1];
      assign prev_ok[k]  = CntW'(k - 1) < cnt_q;
    end
    if (k == TableDepth - 1) begin : g_tail
      assign next_rec[k] = cell_q[0];
      assign next_new[k] = new_q[0];
    end else begin : g_inner
      assign next_rec[k] = cell_q[k+1];
      assign next_new[k] = new_q[k+1];
    end
  end

  // Cell update: insert shifts the lower part down by one and drops the
  // record into the gap; a listing beat rotates the filled part up by one.
  always_comb begin
    for (int k = 0; k < TableDepth; k++) begin
      cell_d[k] = cell_q[k];
      new_d[k]  = new_q[k];
      if (cmd_i.insert) begin
        new_d[k] = 1'b0;
        if (!ge[k]) begin
          if (prev_ge[k]) begin
            cell_d[k] = rec_i;
            new_d[k]  = 1'b1;
          end else if (prev_ok[k]) begin
            cell_d[k] = prev_rec[k];
          end
        end
      end else if (cmd_i.emit) begin
        if (CntW'(k) == cnt_q - CntW'(1)) begin
          cell_d[k] = cell_q[0];
          new_d[k]  = new_q[0];
        end else begin
          cell_d[k] = next_rec[k];
          new_d[k]  = next_new[k];
        end
      end
    end
  end

  // The occupancy grows by one per insert until the table is full.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.insert && (cnt_q != CntW'(TableDepth))) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TableDepth; k++) begin
      cell_q[k] <= cell_d[k];
    end
    new_q <= new_d;
  end

  // Output register: the head cell is captured on every listing beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rec_q  <= cell_q[0];
      out_new_q  <= new_q[0];
      out_rank_q <= cmd_i.rank;
      out_last_q <= cmd_i.last;
    end
  end

  // Status and listing beat outputs.
  assign sts_o.count = CNT_W'(cnt_q);
  assign out_rec_o   = out_rec_q;
  assign out_rank_o  = out_rank_q;
  assign out_new_o   = out_new_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/topk_ctrl.sv */
module topk_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  topk_pkg::sts_t sts_i,
  output topk_pkg::cmd_t cmd_o
);
  import topk_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic              state_q, state_d;
  logic [RANK_W-1:0] idx_q, idx_d;
  logic              ov_q, ov_d;
  logic              fire, is_last;

  // A listing beat moves whenever the output register is free or drained.
  assign fire    = (state_q == StEmit) && (!ov_q || out_ready_i);
  assign is_last = (CNT_W'(idx_q) + CNT_W'(1)) == sts_i.count;

  assign in_ready_o   = (state_q == StIdle);
  assign cmd_o.insert = in_valid_i && (state_q == StIdle);
  assign cmd_o.emit   = fire;
  assign cmd_o.rank   = idx_q;
  assign cmd_o.last   = is_last;
  assign out_valid_o  = ov_q;

  // Sequencer: insert on acceptance, then one beat per stored entry.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.insert) begin
          state_d = StEmit;
          idx_d   = '0;
        end
      end
      StEmit: begin
        if (fire) begin
          if (is_last) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + RANK_W'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    ov_d = ov_q;
    if (fire) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

endmodule

/* rtl/top_k_score_table_top.sv */
// Leaderboard of the best TableDepth records (1 to 64), ordered from the
// highest score down; a new record goes after all stored entries with an
// equal or greater score, and when the table is full the lowest entry falls
// off. Each accepted record is inserted in the accept cycle by a row of
// compare-and-shift cells, after which the whole table is listed, rank 0
// first, one beat per stored entry with last on the final beat and is_new
// on the record just inserted (no beat has is_new when the record ranked
// below a full table). The pace is set by the listing, which rotates the
// table through the head cell one entry per cycle unless the output
// stalls. The input is ready only while no listing is in progress.
module top_k_score_table_top #(
  parameter int unsigned TableDepth = topk_pkg::DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  topk_in_if.sink    in_i,
  topk_out_if.source out_o
);
  import topk_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  record_t rec;
  record_t out_rec;

  assign rec.name  = in_i.name_tag;
  assign rec.score = in_i.score;
  assign rec.stamp = in_i.stamp;

  topk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  topk_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rec_i      (rec),
    .out_rec_o  (out_rec),
    .out_rank_o (out_o.rank),
    .out_new_o  (out_o.is_new),
    .out_last_o (out_o.last)
  );

  assign out_o.entry_name  = out_rec.name;
  assign out_o.entry_score = out_rec.score;
  assign out_o.entry_stamp = out_rec.stamp;

endmodule
